// ===== rtl/core/ctst_pkg.sv =====
// ----------------------------------------------------------------------------
// ctst_pkg
// Shared types, constants and float32 helper functions for the clip-to-screen
// transform pipeline.
// ----------------------------------------------------------------------------
package ctst_pkg;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
	localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;

	// Divider: quotient bits retired per pipeline stage and number of stages.
	localparam int ITERS_PER_STAGE = 4;
	localparam int DIV_STAGES      = 7;
	localparam int QUO_BITS        = ITERS_PER_STAGE * DIV_STAGES;
	localparam int DIV_LAT         = DIV_STAGES + 2;
	localparam int MUL_LAT         = 3;
	localparam int ADD_LAT         = 3;
	localparam int LATENCY         = DIV_LAT + MUL_LAT + ADD_LAT;

	typedef enum logic [2:0] {
		REG_SCALE_X = 3'd0,
		REG_SCALE_Y = 3'd1,
		REG_SCALE_Z = 3'd2,
		REG_SCALE_W = 3'd3,
		REG_SHIFT_X = 3'd4,
		REG_SHIFT_Y = 3'd5,
		REG_SHIFT_Z = 3'd6,
		REG_SHIFT_W = 3'd7
	} reg_idx_t;

	// Special-case class of a result, resolved early and carried down a pipe.
	typedef enum logic [1:0] {
		SP_NONE = 2'd0,
		SP_NAN  = 2'd1,
		SP_INF  = 2'd2,
		SP_ZERO = 2'd3
	} spec_t;

	typedef struct packed {
		logic               sgn;
		logic               nan;
		logic               inf;
		logic               zero;
		logic signed [10:0] ex;
		logic [23:0]        man;
	} fp_t;

	function automatic logic [4:0] lzc24(input logic [23:0] m);
		logic [4:0] lz;
		lz = 5'd24;
		for (int i = 0; i < 24; i++) begin
			if (m[i]) lz = 5'(23 - i);
		end
		return lz;
	endfunction

	function automatic logic [4:0] lzc28(input logic [27:0] m);
		logic [4:0] lz;
		lz = 5'd28;
		for (int i = 0; i < 28; i++) begin
			if (m[i]) lz = 5'(27 - i);
		end
		return lz;
	endfunction

	// Unpacks a float32 and normalizes subnormal significands so that
	// the leading one sits at bit 23 for every nonzero value.
	function automatic fp_t unpack_norm(input logic [31:0] b);
		fp_t        u;
		logic [4:0] lz;
		logic [23:0] m;
		logic [7:0] ef;
		u.sgn  = b[31];
		u.nan  = (&b[30:23]) & (|b[22:0]);
		u.inf  = (&b[30:23]) & ~(|b[22:0]);
		u.zero = ~(|b[30:0]);
		m      = {|b[30:23], b[22:0]};
		lz     = lzc24(m);
		u.man  = m << lz;
		ef     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		u.ex   = $signed({3'b000, ef}) - $signed({6'b000000, lz});
		return u;
	endfunction

	// Rounds to nearest even and packs. The significand has its leading one
	// at bit 26 for a normal value; ex is the biased exponent.
	function automatic logic [31:0] round_pack(input logic sgn,
			input logic signed [10:0] ex, input logic [26:0] mt, input logic stk);
		logic [26:0] m;
		logic        s;
		logic [10:0] sh;
		logic [7:0]  ef;
		logic        rup;
		logic [30:0] mag;
		m  = mt;
		s  = stk;
		ef = ex[7:0];
		sh = 11'd0;
		if (ex >= 11'sd255) begin
			return {sgn, 8'hFF, 23'd0};
		end
		if (ex < 11'sd1) begin
			sh = 11'(11'sd1 - ex);
			ef = 8'd0;
			if (sh > 11'd27) begin
				s = s | (|m);
				m = '0;
			end else begin
				s = s | (|(m & ((27'd1 << sh[4:0]) - 27'd1)));
				m = m >> sh[4:0];
			end
		end
		rup = m[2] & (m[1] | m[0] | s | m[3]);
		mag = {ef, m[25:3]} + 31'(rup);
		return {sgn, mag};
	endfunction

	function automatic logic [31:0] final_pick(input spec_t sp, input logic sgn,
			input logic [31:0] arith);
		logic [31:0] r;
		case (sp)
			SP_NAN:  r = CANON_NAN;
			SP_INF:  r = {sgn, 8'hFF, 23'd0};
			SP_ZERO: r = {sgn, 31'd0};
			default: r = arith;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/clip_to_screen_transform_top.sv =====
// ----------------------------------------------------------------------------
// clip_to_screen_transform_top
// Perspective divide and viewport transform of one clip-space vertex per
// clock: screen_c = (clip_c / clip_w) * scale_c + shift_c in float32.
// ----------------------------------------------------------------------------
//
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------------
// vertex in | start (busy is low)    | clip_x, clip_y, clip_z, clip_w,
//           |                        | last_vertex
// result    | done, one-cycle strobe | screen_x .. screen_w, last_out
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A vertex may be transferred on every clock; busy is always low. The result
// of a vertex passes through the registered stages of the lanes: nine
// stages for the divider (unpack, seven stages of four restoring-division
// steps each, rounding), three for the multiplier and three for the adder.
// The receiver cannot stall, so the pipeline never holds. Reset clears the
// valid chain and loads the scale registers with 1.0 and the shifts with 0.0.
// Configuration transfers are taken on every cycle.
// ----------------------------------------------------------------------------
module clip_to_screen_transform_top import ctst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] clip_x,
	input  logic [31:0] clip_y,
	input  logic [31:0] clip_z,
	input  logic [31:0] clip_w,
	input  logic        last_vertex,
	output logic        done,
	output logic [31:0] screen_x,
	output logic [31:0] screen_y,
	output logic [31:0] screen_z,
	output logic [31:0] screen_w,
	output logic        last_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// The pipeline never backs up, so both channels are always open.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	logic [31:0] scale_q [0:3];
	logic [31:0] shift_q [0:3];

	// Register writes. The user must change configuration only while no vertex
	// is in flight; not enforced here. The lanes read these registers directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				scale_q[i] <= ONE_BITS;
				shift_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_SCALE_X: scale_q[0] <= cfg_data;
				REG_SCALE_Y: scale_q[1] <= cfg_data;
				REG_SCALE_Z: scale_q[2] <= cfg_data;
				REG_SCALE_W: scale_q[3] <= cfg_data;
				REG_SHIFT_X: shift_q[0] <= cfg_data;
				REG_SHIFT_Y: shift_q[1] <= cfg_data;
				REG_SHIFT_Z: shift_q[2] <= cfg_data;
				REG_SHIFT_W: shift_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits and the last-vertex flag ride alongside the lanes in a
	// delay line as long as the arithmetic pipeline.
	logic accept;
	logic [LATENCY-1:0] vld_q;
	logic [LATENCY-1:0] last_q;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			last_q <= '0;
		end else begin
			vld_q  <= {vld_q[LATENCY-2:0], accept};
			last_q <= {last_q[LATENCY-2:0], accept && last_vertex};
		end
	end

	assign done     = vld_q[LATENCY-1];
	assign last_out = last_q[LATENCY-1];

	// Four identical lanes; the w lane divides w by itself like the others.
	logic [31:0] clip_v  [0:3];
	logic [31:0] quo     [0:3];
	logic [31:0] prod    [0:3];
	logic [31:0] res     [0:3];

	assign clip_v[0] = clip_x;
	assign clip_v[1] = clip_y;
	assign clip_v[2] = clip_z;
	assign clip_v[3] = clip_w;

	for (genvar c = 0; c < 4; c++) begin : g_lane
		ctst_div u_div (
			.clk (clk),
			.num (clip_v[c]),
			.den (clip_w),
			.quo (quo[c])
		);
		ctst_mul u_mul (
			.clk (clk),
			.a   (quo[c]),
			.b   (scale_q[c]),
			.p   (prod[c])
		);
		ctst_add u_add (
			.clk (clk),
			.a   (prod[c]),
			.b   (shift_q[c]),
			.s   (res[c])
		);
	end

	assign screen_x = res[0];
	assign screen_y = res[1];
	assign screen_z = res[2];
	assign screen_w = res[3];

`ifndef NO_ASSERTIONS
	// Every result strobe belongs to an earlier vertex transfer.
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching input transfer");

	// The last-vertex mark never shows outside a result.
	a_last_only_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !last_out)
		else $error("last_out raised without a result");

	// A scale write lands in the register on the next cycle.
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == REG_SCALE_X) |=>
		(scale_q[0] == $past(cfg_data)))
		else $error("scale_x write lost");
`endif

endmodule

// ===== rtl/core/ctst_div.sv =====
// ----------------------------------------------------------------------------
// ctst_div
// Pipelined float32 divider: unpack stage, restoring-division stages and a
// rounding stage.
// ----------------------------------------------------------------------------
module ctst_div import ctst_pkg::*; (
	input  logic        clk,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic [31:0] quo
);

	fp_t ua, ub;
	logic signed [10:0] ex0;
	logic [25:0] rem0;
	spec_t sp0;

	logic [25:0]        rem_s [0:DIV_STAGES];
	logic [QUO_BITS-1:0] q_s  [0:DIV_STAGES];
	logic [23:0]        dvs_s [0:DIV_STAGES];
	logic signed [10:0] ex_s  [0:DIV_STAGES];
	logic               sgn_s [0:DIV_STAGES];
	spec_t              sp_s  [0:DIV_STAGES];

	always_comb begin
		ua = unpack_norm(num);
		ub = unpack_norm(den);
		ex0 = ua.ex - ub.ex + 11'sd127;
		if (ua.man < ub.man) begin
			rem0 = {1'b0, ua.man, 1'b0};
			ex0  = ex0 - 11'sd1;
		end else begin
			rem0 = {2'b00, ua.man};
		end
		if (ua.nan || ub.nan || (ua.zero && ub.zero) || (ua.inf && ub.inf))
			sp0 = SP_NAN;
		else if (ua.inf || ub.zero)
			sp0 = SP_INF;
		else if (ua.zero || ub.inf)
			sp0 = SP_ZERO;
		else
			sp0 = SP_NONE;
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= rem0;
		q_s[0]   <= '0;
		dvs_s[0] <= ub.man;
		ex_s[0]  <= ex0;
		sgn_s[0] <= ua.sgn ^ ub.sgn;
		sp_s[0]  <= sp0;
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_it
		logic [25:0]         r;
		logic [QUO_BITS-1:0] q;
		always_comb begin
			r = rem_s[k];
			q = q_s[k];
			for (int j = 0; j < ITERS_PER_STAGE; j++) begin
				if (r >= {2'b00, dvs_s[k]}) begin
					r = r - {2'b00, dvs_s[k]};
					q = {q[QUO_BITS-2:0], 1'b1};
				end else begin
					q = {q[QUO_BITS-2:0], 1'b0};
				end
				r = {r[24:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			rem_s[k+1] <= r;
			q_s[k+1]   <= q;
			dvs_s[k+1] <= dvs_s[k];
			ex_s[k+1]  <= ex_s[k];
			sgn_s[k+1] <= sgn_s[k];
			sp_s[k+1]  <= sp_s[k];
		end
	end

	// The quotient's top 27 bits feed rounding; the rest and the remainder
	// collapse into the sticky bit.
	always_ff @(posedge clk) begin
		quo <= final_pick(sp_s[DIV_STAGES], sgn_s[DIV_STAGES],
			round_pack(sgn_s[DIV_STAGES], ex_s[DIV_STAGES],
				q_s[DIV_STAGES][QUO_BITS-1 -: 27],
				(|q_s[DIV_STAGES][QUO_BITS-28:0]) | (|rem_s[DIV_STAGES])));
	end

endmodule

// ===== rtl/core/ctst_mul.sv =====
// ----------------------------------------------------------------------------
// ctst_mul
// Three-stage float32 multiplier: unpack, 24x24 product, round.
// ----------------------------------------------------------------------------
module ctst_mul import ctst_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] p
);

	fp_t ua, ub;
	spec_t sp0;

	logic [23:0]        ma_s1, mb_s1;
	logic signed [10:0] ex_s1, ex_s2;
	logic               sgn_s1, sgn_s2;
	spec_t              sp_s1, sp_s2;
	logic [47:0]        prod_s2;

	logic [26:0]        mant;
	logic               stk;
	logic signed [10:0] exr;

	always_comb begin
		ua = unpack_norm(a);
		ub = unpack_norm(b);
		if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf))
			sp0 = SP_NAN;
		else if (ua.inf || ub.inf)
			sp0 = SP_INF;
		else if (ua.zero || ub.zero)
			sp0 = SP_ZERO;
		else
			sp0 = SP_NONE;
	end

	always_ff @(posedge clk) begin
		ma_s1  <= ua.man;
		mb_s1  <= ub.man;
		ex_s1  <= ua.ex + ub.ex - 11'sd127;
		sgn_s1 <= ua.sgn ^ ub.sgn;
		sp_s1  <= sp0;
	end

	always_ff @(posedge clk) begin
		prod_s2 <= ma_s1 * mb_s1;
		ex_s2   <= ex_s1;
		sgn_s2  <= sgn_s1;
		sp_s2   <= sp_s1;
	end

	always_comb begin
		if (prod_s2[47]) begin
			mant = prod_s2[47:21];
			stk  = |prod_s2[20:0];
			exr  = ex_s2 + 11'sd1;
		end else begin
			mant = prod_s2[46:20];
			stk  = |prod_s2[19:0];
			exr  = ex_s2;
		end
	end

	always_ff @(posedge clk) begin
		p <= final_pick(sp_s2, sgn_s2, round_pack(sgn_s2, exr, mant, stk));
	end

endmodule

// ===== rtl/core/ctst_add.sv =====
// ----------------------------------------------------------------------------
// ctst_add
// Three-stage float32 adder: swap and align, add with leading-zero count,
// normalize and round.
// ----------------------------------------------------------------------------
module ctst_add import ctst_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] s
);

	logic [31:0] big, sml;
	logic [7:0]  eb, es, d;
	logic [26:0] mb, ms, ms_al;
	logic        an, bn, ai, bi;
	spec_t       sp0;
	logic        spsg0;

	logic [26:0] ma_s1, mb_s1;
	logic [7:0]  ex_s1, ex_s2;
	logic        sub_s1, sgn_s1, sub_s2, sgn_s2;
	spec_t       sp_s1, sp_s2;
	logic [27:0] sum, sum_s2;
	logic [4:0]  lz_s2;

	logic [4:0]         sh;
	logic [27:0]        t;
	logic [26:0]        mant;
	logic signed [10:0] exr;
	spec_t              spf;
	logic               sgf;

	always_comb begin
		an = (&a[30:23]) & (|a[22:0]);
		bn = (&b[30:23]) & (|b[22:0]);
		ai = (&a[30:23]) & ~(|a[22:0]);
		bi = (&b[30:23]) & ~(|b[22:0]);
		if (a[30:0] >= b[30:0]) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		mb = {|big[30:23], big[22:0], 3'b000};
		ms = {|sml[30:23], sml[22:0], 3'b000};
		d  = eb - es;
		if (d >= 8'd27)
			ms_al = {26'd0, |ms};
		else
			ms_al = (ms >> d[4:0]) | {26'd0, |(ms & ((27'd1 << d[4:0]) - 27'd1))};
		spsg0 = ai ? a[31] : b[31];
		if (an || bn || (ai && bi && (a[31] != b[31])))
			sp0 = SP_NAN;
		else if (ai || bi)
			sp0 = SP_INF;
		else
			sp0 = SP_NONE;
	end

	always_ff @(posedge clk) begin
		ma_s1  <= mb;
		mb_s1  <= ms_al;
		ex_s1  <= eb;
		sub_s1 <= big[31] ^ sml[31];
		sgn_s1 <= (sp0 == SP_INF) ? spsg0 : big[31];
		sp_s1  <= sp0;
	end

	always_comb begin
		if (sub_s1)
			sum = {1'b0, ma_s1} - {1'b0, mb_s1};
		else
			sum = {1'b0, ma_s1} + {1'b0, mb_s1};
	end

	always_ff @(posedge clk) begin
		sum_s2 <= sum;
		lz_s2  <= lzc28(sum);
		ex_s2  <= ex_s1;
		sub_s2 <= sub_s1;
		sgn_s2 <= sgn_s1;
		sp_s2  <= sp_s1;
	end

	// An exact cancellation gives +0; two zeros of the same sign keep it.
	always_comb begin
		sh  = lz_s2 - 5'd1;
		t   = sum_s2 << sh;
		spf = sp_s2;
		sgf = sgn_s2;
		if (sum_s2[27]) begin
			mant = sum_s2[27:1] | {26'd0, sum_s2[0]};
			exr  = $signed({3'b000, ex_s2}) + 11'sd1;
		end else begin
			mant = t[26:0];
			exr  = $signed({3'b000, ex_s2}) - $signed({6'd0, sh});
		end
		if (sp_s2 == SP_NONE && sum_s2 == 28'd0) begin
			spf = SP_ZERO;
			sgf = sub_s2 ? 1'b0 : sgn_s2;
		end
	end

	always_ff @(posedge clk) begin
		s <= final_pick(spf, sgf, round_pack(sgn_s2, exr, mant, 1'b0));
	end

endmodule
